/* hdl/hsv2rgb_pkg.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_pkg - shared types and constants for the HSV to RGB converter
// Hue format, sector codes and default component width.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int COMPONENT_BITS_DEF = 8;

  // Hue: sector in the bits above the fraction, 256 steps per sector
  localparam int HUE_W  = 11;
  localparam int FRAC_W = 8;
  localparam int SECT_W = HUE_W - FRAC_W;

  localparam logic [HUE_W-1:0]  FULL_TURN  = 11'd1536;
  localparam logic [FRAC_W:0]   FRAC_STEPS = 9'd256;

  // Color wheel sectors, in hue order
  typedef enum logic [SECT_W-1:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

endpackage

/* hdl/hsv2rgb_front.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_front - hue decode and term products
// Four stages: wrap hue and form s*f terms, subtract from 256*M,
// multiply by value, add rounding offsets ahead of the divide by M.
// ---------------------------------------------------------------------------
module hsv2rgb_front
  import hsv2rgb_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [HUE_W-1:0]              hue,
  input  logic [COMPONENT_BITS-1:0]     sat,
  input  logic [COMPONENT_BITS-1:0]     val,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sector_t                       out_sect,
  output logic [COMPONENT_BITS-1:0]     out_val,
  output logic [2*COMPONENT_BITS-1:0]   out_yp,
  output logic [2*COMPONENT_BITS-1:0]   out_yq,
  output logic [2*COMPONENT_BITS-1:0]   out_yt
);

  localparam int N      = COMPONENT_BITS;
  localparam int BIG_W  = N + FRAC_W;
  localparam int Y_W    = 2 * N;
  localparam int PROD_W = 2 * N + FRAC_W;
  localparam int STAGES = 4;

  localparam logic [N-1:0]      COMP_MAX = {N{1'b1}};
  localparam logic [BIG_W-1:0]  BIG      = {COMP_MAX, {FRAC_W{1'b0}}};
  localparam logic [Y_W-1:0]    HALF_M   = Y_W'(COMP_MAX >> 1);
  localparam logic [PROD_W-1:0] RND_Q    = PROD_W'({COMP_MAX, {(FRAC_W-1){1'b0}}});

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] en;

  // stage 1
  logic [HUE_W-1:0] hue_wrap;
  logic [FRAC_W:0]  frac_c;
  sector_t          s1_sect_r;
  logic [N-1:0]     s1_val_r, s1_ms_r, ms_nxt;
  logic [BIG_W-1:0] s1_sf_r, s1_sfc_r, sf_nxt, sfc_nxt;
  // stage 2
  sector_t          s2_sect_r;
  logic [N-1:0]     s2_val_r, s2_ms_r;
  logic [BIG_W-1:0] s2_aq_r, s2_at_r, aq_nxt, at_nxt;
  // stage 3
  sector_t           s3_sect_r;
  logic [N-1:0]      s3_val_r;
  logic [Y_W-1:0]    s3_pp_r, pp_nxt;
  logic [PROD_W-1:0] s3_pq_r, s3_pt_r, pq_nxt, pt_nxt;
  // stage 4
  logic [PROD_W-1:0] q_sum, t_sum;
  sector_t           s4_sect_r;
  logic [N-1:0]      s4_val_r;
  logic [Y_W-1:0]    s4_yp_r, s4_yq_r, s4_yt_r, yp_nxt, yq_nxt, yt_nxt;

  // A stage loads when it is empty or the next one moves on
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: wrap a full turn, split sector and fraction
  always_comb begin
    hue_wrap = (hue >= FULL_TURN) ? hue - FULL_TURN : hue;
    frac_c   = FRAC_STEPS - {1'b0, hue_wrap[FRAC_W-1:0]};
    sf_nxt   = BIG_W'(sat) * BIG_W'(hue_wrap[FRAC_W-1:0]);
    sfc_nxt  = BIG_W'(sat) * BIG_W'(frac_c);
    ms_nxt   = COMP_MAX - sat;
  end

  // Stage 2: 256*M minus the saturation terms
  assign aq_nxt = BIG - s1_sf_r;
  assign at_nxt = BIG - s1_sfc_r;

  // Stage 3: scale by value
  assign pp_nxt = Y_W'(s2_val_r) * Y_W'(s2_ms_r);
  assign pq_nxt = PROD_W'(s2_val_r) * PROD_W'(s2_aq_r);
  assign pt_nxt = PROD_W'(s2_val_r) * PROD_W'(s2_at_r);

  // Stage 4: fold the round-half-up offset in, drop the fraction scale
  assign q_sum  = s3_pq_r + RND_Q;
  assign t_sum  = s3_pt_r + RND_Q;
  assign yp_nxt = s3_pp_r + HALF_M;
  assign yq_nxt = q_sum[PROD_W-1:FRAC_W];
  assign yt_nxt = t_sum[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sect_r <= sector_t'(hue_wrap[HUE_W-1:FRAC_W]);
      s1_val_r  <= val;
      s1_ms_r   <= ms_nxt;
      s1_sf_r   <= sf_nxt;
      s1_sfc_r  <= sfc_nxt;
    end
    if (en[1]) begin
      s2_sect_r <= s1_sect_r;
      s2_val_r  <= s1_val_r;
      s2_ms_r   <= s1_ms_r;
      s2_aq_r   <= aq_nxt;
      s2_at_r   <= at_nxt;
    end
    if (en[2]) begin
      s3_sect_r <= s2_sect_r;
      s3_val_r  <= s2_val_r;
      s3_pp_r   <= pp_nxt;
      s3_pq_r   <= pq_nxt;
      s3_pt_r   <= pt_nxt;
    end
    if (en[3]) begin
      s4_sect_r <= s3_sect_r;
      s4_val_r  <= s3_val_r;
      s4_yp_r   <= yp_nxt;
      s4_yq_r   <= yq_nxt;
      s4_yt_r   <= yt_nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_sect  = s4_sect_r;
  assign out_val   = s4_val_r;
  assign out_yp    = s4_yp_r;
  assign out_yq    = s4_yq_r;
  assign out_yt    = s4_yt_r;

endmodule

/* hdl/hsv2rgb_back.sv */
// ---------------------------------------------------------------------------
// hsv2rgb_back - divide by 2^N-1 and sector permutation
// Two stages: estimate quotient by shift-add, then correct by one and
// route v, p, q, t onto red, green and blue.
// ---------------------------------------------------------------------------
module hsv2rgb_back
  import hsv2rgb_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sector_t                       sect,
  input  logic [COMPONENT_BITS-1:0]     val,
  input  logic [2*COMPONENT_BITS-1:0]   yp,
  input  logic [2*COMPONENT_BITS-1:0]   yq,
  input  logic [2*COMPONENT_BITS-1:0]   yt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COMPONENT_BITS-1:0]     red,
  output logic [COMPONENT_BITS-1:0]     green,
  output logic [COMPONENT_BITS-1:0]     blue
);

  localparam int N     = COMPONENT_BITS;
  localparam int Y_W   = 2 * N;
  localparam int LANES = 3;   // p, q, t

  localparam logic [N-1:0] COMP_MAX = {N{1'b1}};

  logic           vld5_r, vld6_r;
  logic           en5, en6;

  logic [Y_W-1:0] y_in [LANES];
  logic [Y_W-1:0] est_sum [LANES];
  logic [N-1:0]   qa_nxt [LANES];
  logic [Y_W-1:0] s5_y_r [LANES];
  logic [N-1:0]   s5_qa_r [LANES];
  sector_t        s5_sect_r;
  logic [N-1:0]   s5_val_r;

  logic [Y_W-1:0] rem [LANES];
  logic [N-1:0]   quo [LANES];
  logic [N-1:0]   red_nxt, green_nxt, blue_nxt;
  logic [N-1:0]   red_r, green_r, blue_r;

  assign en6      = !vld6_r || out_ready;
  assign en5      = !vld5_r || en6;
  assign in_ready = en5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (en5) begin
        vld5_r <= in_valid;
      end
      if (en6) begin
        vld6_r <= vld5_r;
      end
    end
  end

  assign y_in[0] = yp;
  assign y_in[1] = yq;
  assign y_in[2] = yt;

  // Stage 5: y/M ~ (y + y>>N) >> N, low by at most one
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      est_sum[i] = y_in[i] + (y_in[i] >> N);
      qa_nxt[i]  = est_sum[i][Y_W-1:N];
    end
  end

  // Stage 6: remainder check, bump the estimate when it reaches M
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rem[i] = s5_y_r[i] - {s5_qa_r[i], {N{1'b0}}} + Y_W'(s5_qa_r[i]);
      quo[i] = (rem[i] >= Y_W'(COMP_MAX)) ? s5_qa_r[i] + 1'b1 : s5_qa_r[i];
    end
    case (s5_sect_r)
      SECT_RED: begin
        red_nxt = s5_val_r; green_nxt = quo[2];   blue_nxt = quo[0];
      end
      SECT_YELLOW: begin
        red_nxt = quo[1];   green_nxt = s5_val_r; blue_nxt = quo[0];
      end
      SECT_GREEN: begin
        red_nxt = quo[0];   green_nxt = s5_val_r; blue_nxt = quo[2];
      end
      SECT_CYAN: begin
        red_nxt = quo[0];   green_nxt = quo[1];   blue_nxt = s5_val_r;
      end
      SECT_BLUE: begin
        red_nxt = quo[2];   green_nxt = quo[0];   blue_nxt = s5_val_r;
      end
      default: begin
        red_nxt = s5_val_r; green_nxt = quo[0];   blue_nxt = quo[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < LANES; i++) begin
        s5_y_r[i]  <= y_in[i];
        s5_qa_r[i] <= qa_nxt[i];
      end
      s5_sect_r <= sect;
      s5_val_r  <= val;
    end
    if (en6) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vld6_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

/* hdl/hsv_to_rgb_converter.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter - streaming HSV to RGB pixel converter
// One pixel in, one pixel out; six-stage pipeline with per-stage valids.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry hue, saturation and brightness on in_tdata; output
//   beats carry red, green and blue on out_tdata. A beat moves when tvalid
//   and tready are both high at a rising clock edge.
//   Hue counts 256 steps per color wheel sector, 1536 per turn; values
//   from 1536 up wrap by one turn. Components use 2^N-1 as full scale.
//   On the way from input beat to output beat, four stages form
//   the v*(M-s) and v*(256M - s*f) products, two more divide by M (shift-add
//   estimate plus a one-step correction) and select the sector permutation.
//   With no stall, one pixel per cycle; each stage holds at most one beat.
//   When the receiver drops out_tready, full stages hold while empty stages
//   still advance, so in_tready stays high until every stage holds a beat.
//   Synchronous reset (rst_n low) empties the pipeline; no beat is lost or
//   repeated across a stall.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, low bit up: hue, saturation, brightness, zero pad
  input  logic                                                  in_tvalid,
  output logic                                                  in_tready,
  input  logic [((HUE_W + 2*COMPONENT_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata, low bit up: red, green, blue, zero pad
  output logic                                                  out_tvalid,
  input  logic                                                  out_tready,
  output logic [((3*COMPONENT_BITS + 7) / 8) * 8 - 1:0]         out_tdata
);

  localparam int N      = COMPONENT_BITS;
  localparam int OUT_TW = ((3 * N + 7) / 8) * 8;

  // Unpack the input beat
  logic [HUE_W-1:0] hue;
  logic [N-1:0]     saturation, brightness;

  assign hue        = in_tdata[HUE_W-1:0];
  assign saturation = in_tdata[HUE_W+N-1:HUE_W];
  assign brightness = in_tdata[HUE_W+2*N-1:HUE_W+N];

  // Front to back hand-off
  logic           mid_valid, mid_ready;
  sector_t        mid_sect;
  logic [N-1:0]   mid_val;
  logic [2*N-1:0] mid_yp, mid_yq, mid_yt;

  logic [N-1:0]   red, green, blue;

  // Hue decode, saturation terms, value products, rounding offsets
  hsv2rgb_front #(
    .COMPONENT_BITS (N)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .hue       (hue),
    .sat       (saturation),
    .val       (brightness),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_sect  (mid_sect),
    .out_val   (mid_val),
    .out_yp    (mid_yp),
    .out_yq    (mid_yq),
    .out_yt    (mid_yt)
  );

  // Divide by full scale, permute by sector, hold the output register
  hsv2rgb_back #(
    .COMPONENT_BITS (N)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .sect      (mid_sect),
    .val       (mid_val),
    .yp        (mid_yp),
    .yq        (mid_yq),
    .yt        (mid_yt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // Pack the output beat, pad with zeros to whole bytes
  assign out_tdata = OUT_TW'({blue, green, red});

endmodule

/* tb/hsv_to_rgb_converter_test.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_test - self-checking bench for the HSV to RGB converter
// Drives pixel beats with random idle cycles and output back-pressure.
// An in-bench color model predicts red, green and blue for every accepted beat.
// Each output beat is checked field by field, in order, against that model.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB       = COMPONENT_BITS_DEF;
  localparam int COMP_MAX = (1 << CB) - 1;
  localparam int IN_W     = ((HUE_W + 2*CB + 7) / 8) * 8;
  localparam int OUT_W    = ((3*CB + 7) / 8) * 8;
  localparam int HUE_TOP  = (1 << HUE_W) - 1;
  localparam int PIPE_LAT = 6;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // in_tdata, low bit up: hue, saturation, brightness, zero pad
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  // out_tdata, low bit up: red, green, blue, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // high while neither side may idle
  logic steady = 1'b0;

  rgb_t rgb_due[$];
  int   mismatches   = 0;
  int   pixels_sent  = 0;
  int   pixels_seen  = 0;
  int   wrapped_hues = 0;
  int   grey_pixels  = 0;

  hsv_to_rgb_converter #(.COMPONENT_BITS(CB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // round(num / den), halves go up
  function automatic int round_half_up(input int num, input int den);
    return (2*num + den) / (2*den);
  endfunction

  // Color model: hue wraps by one turn, sector picks the permutation
  function automatic rgb_t hsv_to_rgb(input logic [HUE_W-1:0] hue_in,
                                      input logic [CB-1:0] sat,
                                      input logic [CB-1:0] val);
    logic [HUE_W-1:0] hue;
    sector_t          sect;
    int               frac;
    int               full;
    int               p, q, t, v;
    rgb_t             px;
    hue = (hue_in >= FULL_TURN) ? hue_in - FULL_TURN : hue_in;
    v   = int'(val);
    if (sat == 0) begin
      px = '{red: val, green: val, blue: val};
      return px;
    end
    sect = sector_t'(hue[HUE_W-1:FRAC_W]);
    frac = int'(hue[FRAC_W-1:0]);
    full = COMP_MAX * int'(FRAC_STEPS);
    p = round_half_up(v * (COMP_MAX - int'(sat)), COMP_MAX);
    q = round_half_up(v * (full - int'(sat) * frac), full);
    t = round_half_up(v * (full - int'(sat) * (int'(FRAC_STEPS) - frac)), full);
    case (sect)
      SECT_RED:    px = '{red: CB'(v), green: CB'(t), blue: CB'(p)};
      SECT_YELLOW: px = '{red: CB'(q), green: CB'(v), blue: CB'(p)};
      SECT_GREEN:  px = '{red: CB'(p), green: CB'(v), blue: CB'(t)};
      SECT_CYAN:   px = '{red: CB'(p), green: CB'(q), blue: CB'(v)};
      SECT_BLUE:   px = '{red: CB'(t), green: CB'(p), blue: CB'(v)};
      default:     px = '{red: CB'(v), green: CB'(p), blue: CB'(q)};
    endcase
    return px;
  endfunction

  // Monitor: predict on every input beat, then check every output beat
  always @(posedge clk) begin
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    sat, val;
    rgb_t             want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hue = in_tdata[HUE_W-1:0];
        sat = in_tdata[HUE_W +: CB];
        val = in_tdata[HUE_W+CB +: CB];
        rgb_due.push_back(hsv_to_rgb(hue, sat, val));
        if (hue >= FULL_TURN) wrapped_hues++;
        if (sat == 0) grey_pixels++;
      end
      if (out_tvalid && out_tready) begin
        got.red   = out_tdata[0 +: CB];
        got.green = out_tdata[CB +: CB];
        got.blue  = out_tdata[2*CB +: CB];
        pixels_seen++;
        if (rgb_due.size() == 0) begin
          $error("unexpected output beat rgb=%h", got);
          mismatches++;
        end else begin
          want = rgb_due.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver back-pressure: drop out_tready about 20% of cycles unless steady
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 20);
  end

  // Send one pixel beat. Call at a falling edge; returns at a falling edge
  // with in_tvalid still high, so back-to-back beats need no gap.
  task automatic send_pixel(input int hue, input int sat, input int val);
    while (!steady && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - HUE_W - 2*CB){1'b0}}, CB'(val), CB'(sat), HUE_W'(hue)};
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (rgb_due.size() != 0) @(negedge clk);
  endtask

  // Mostly in-range hues, some past a full turn, some on sector edges
  function automatic int rand_hue();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return int'($urandom_range(int'(FULL_TURN)));
    if (pick < 92) return int'($urandom_range(HUE_TOP, int'(FULL_TURN) + 1));
    return int'(($urandom_range(6) * 256 + $urandom_range(1) * 255) & HUE_TOP);
  endfunction

  // Components with extra weight on zero and full scale
  function automatic int rand_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 20) return COMP_MAX;
    return int'($urandom_range(COMP_MAX));
  endfunction

  // Full-turn wrap, hue past a turn, and component extremes
  task automatic test_extremes();
    send_pixel(0, 0, 0);
    send_pixel(0, COMP_MAX, COMP_MAX);
    send_pixel(int'(FULL_TURN), COMP_MAX, COMP_MAX);
    send_pixel(int'(FULL_TURN) - 1, COMP_MAX, COMP_MAX);
    send_pixel(int'(FULL_TURN) + 1, COMP_MAX, 200);
    send_pixel(HUE_TOP, COMP_MAX, COMP_MAX);
    send_pixel(HUE_TOP, 1, 1);
    send_pixel(1024, COMP_MAX, 0);
    // zero saturation gives grey whatever the hue
    send_pixel(700, 0, 123);
    send_pixel(HUE_TOP, 0, COMP_MAX);
    go_quiet();
  endtask

  // Every sector at its start, middle and end fraction
  task automatic test_sectors();
    for (int sect = SECT_RED; sect <= SECT_MAGENTA; sect++) begin
      send_pixel(sect * 256,       COMP_MAX, COMP_MAX);
      send_pixel(sect * 256 + 128, 170,      COMP_MAX);
      send_pixel(sect * 256 + 255, COMP_MAX, 99);
    end
    go_quiet();
  endtask

  // Random pixels with idling on both sides
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_hue(), rand_comp(), rand_comp());
    go_quiet();
  endtask

  // Long stretch at full rate: no idle cycles, no back-pressure
  task automatic test_full_rate(input int count);
    steady <= 1'b1;
    for (int i = 0; i < count; i++) send_pixel(rand_hue(), rand_comp(), rand_comp());
    go_quiet();
    steady <= 1'b0;
  endtask

  // Hold the sender until the pipeline is empty, then restart traffic
  task automatic test_pause_until_drained(input int bursts, input int burst_len);
    for (int b = 0; b < bursts; b++) begin
      for (int i = 0; i < burst_len; i++) begin
        send_pixel(rand_hue(), rand_comp(), rand_comp());
      end
      go_quiet();
      wait_drained();
    end
  endtask

  initial begin
    // hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_sectors();
    test_random_traffic(700);
    test_pause_until_drained(10, 20);
    test_full_rate(300);
    test_random_traffic(450);

    wait_drained();
    repeat (PIPE_LAT * 3) @(negedge clk);
    if (rgb_due.size() != 0) begin
      $error("%0d expected pixels never arrived", rgb_due.size());
      mismatches++;
    end

    $display("tb: %0d pixels sent, %0d checked; %0d hues past a full turn, %0d grey",
             pixels_sent, pixels_seen, wrapped_hues, grey_pixels);
    $display("tb: all six sectors, extremes, idle gaps, stalls and a full-rate stretch");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_front.sv
hdl/hsv2rgb_back.sv
hdl/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_test.sv
